[src/fbfl_pkg.sv]
// Shared types, codes and constants of the fixed block free list allocator.
package fbfl_pkg;

    // Pool geometry
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned LINK_W  = 11;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned DEPTH   = 1 << IDX_W;
    localparam logic [COUNT_W-1:0] MAX_BLOCKS = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;

    // Request kinds
    localparam logic [1:0] ACT_ALLOC    = 2'd0;
    localparam logic [1:0] ACT_RELEASE  = 2'd1;
    localparam logic [1:0] ACT_TEARDOWN = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NULL    = 3'd1;
    localparam logic [2:0] STAT_STATE   = 3'd2;
    localparam logic [2:0] STAT_OWNER   = 3'd3;
    localparam logic [2:0] STAT_INUSE   = 3'd4;
    localparam logic [2:0] STAT_NOBLOCK = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_BLOCKS = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd1;
    localparam logic [1:0] CFG_FAILOVER   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_INIT,
        S_POP,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic eval_commit;
        logic mem_read;
        logic init_start;
        logic init_step;
        logic pop_commit;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_init;
        logic need_read;
        logic init_last;
        logic out_busy;
    } dp_stat_t;

endpackage

[src/fixed_block_free_list_allocator_unit.sv]
// Top level of the fixed block free list allocator.
//
// Manages a pool of up to 1024 equal-size blocks as a LIFO free list held in
// an internal 1024 x 11 link memory. One request beat in, one result beat out.
// A release, a teardown, an unused action or an allocate that takes no block
// passes from idle through the evaluate and done states; an allocate that pops
// a block also passes the pop state, for the registered read of the link memory
// for the head's successor. The first allocate after reset or teardown links
// every block first: one link memory write per block (num_blocks, clamped at
// 1024), then the request is evaluated again. The link memory has no
// clearing pass. A result waits in an output register, and the next request
// beat is taken while it waits; that request then holds in its last cycle for
// as long as the waiting beat is not taken. Configuration writes are always
// ready and must be issued only while no request is in flight.
module fixed_block_free_list_allocator_unit
    import fbfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: request_size[15:0], handle_present[16], block_index[26:17], zero[31:27]
    input  logic [31:0] s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[2:0], granted_index[12:3], forwarded[13], zero[15:14]
    output logic [15:0] m_axis_tdata
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [2:0]       res_status;
    logic [IDX_W-1:0] res_granted;
    logic             res_fwd;

    assign cfg_ready = 1'b1;

    // Sequence each request
    fbfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold pool state and do the work
    fbfl_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_action         (s_axis_tuser),
        .in_request_size   (s_axis_tdata[15:0]),
        .in_handle_present (s_axis_tdata[16]),
        .in_block_index    (s_axis_tdata[26:17]),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_status        (res_status),
        .out_granted_index (res_granted),
        .out_forwarded     (res_fwd)
    );

    // Pack the result beat
    assign m_axis_tdata = {2'b00, res_fwd, res_granted, res_status};

    // One request at a time: the input is not ready in the cycle after an accepted beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A forwarded result always reports ok and no granted block
    a_fwd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_fwd) |-> (res_status == STAT_OK && res_granted == '0))
        else $error("forwarded result with non-ok status or a grant");

    // A new result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrites a beat not yet taken");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res_status <= STAT_NOBLOCK))
        else $error("undefined status code");

endmodule

[src/fbfl_ctrl.sv]
// Sequencing state machine of the fixed block free list allocator.
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.need_init)
                begin
                    state_next = S_INIT;
                end
                else if (stat.need_read)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INIT:
            begin
                if (stat.init_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_POP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_EVAL:
            begin
                if (stat.need_init)
                begin
                    cmd.init_start = 1'b1;
                end
                else if (stat.need_read)
                begin
                    cmd.mem_read = 1'b1;
                end
                else
                begin
                    cmd.eval_commit = 1'b1;
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
            end
            S_POP:
            begin
                cmd.pop_commit = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/fbfl_datapath.sv]
// Pool state, link memory, configuration and result registers of the allocator.
module fbfl_datapath
    import fbfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         in_action,
    input  logic [SIZE_W-1:0]  in_request_size,
    input  logic               in_handle_present,
    input  logic [IDX_W-1:0]   in_block_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_status,
    output logic [IDX_W-1:0]   out_granted_index,
    output logic               out_forwarded
);

    // Configuration registers
    logic [COUNT_W-1:0] num_blocks_reg;
    logic [SIZE_W-1:0]  block_size_reg;
    logic               failover_reg;

    // Captured item
    logic [1:0]         action_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               handle_reg;
    logic [IDX_W-1:0]   index_reg;

    // Pool state
    logic               pool_ready_reg;
    logic               pool_ready_next;
    logic [IDX_W-1:0]   free_head_reg;
    logic [IDX_W-1:0]   free_head_next;
    logic               head_valid_reg;
    logic               head_valid_next;
    logic [COUNT_W-1:0] free_count_reg;
    logic [COUNT_W-1:0] free_count_next;
    logic [IDX_W-1:0]   init_cnt_reg;

    // Link memory
    logic [LINK_W-1:0]  link_mem [DEPTH];
    logic [LINK_W-1:0]  link_rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [LINK_W-1:0]  mem_wdata;

    // Result and output registers
    logic [2:0]         res_status_reg;
    logic [IDX_W-1:0]   res_granted_reg;
    logic               res_fwd_reg;
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [IDX_W-1:0]   out_granted_reg;
    logic               out_fwd_reg;

    // Evaluation of the captured item
    logic [COUNT_W-1:0] active;
    logic [2:0]         eval_status;
    logic               eval_fwd;
    logic               release_ok;
    logic               teardown_ok;
    logic               init_last;
    logic               need_init;
    logic               need_read;

    // Clamp the block count to the pool depth
    assign active = (num_blocks_reg > MAX_BLOCKS) ? MAX_BLOCKS : num_blocks_reg;
    assign init_last = ({1'b0, init_cnt_reg} == (active - 11'd1));

    // Decide the outcome of the captured request
    always_comb
    begin
        eval_status = STAT_OK;
        eval_fwd    = 1'b0;
        release_ok  = 1'b0;
        teardown_ok = 1'b0;
        need_init   = 1'b0;
        need_read   = 1'b0;
        case (action_reg)
            ACT_ALLOC:
            begin
                if (!pool_ready_reg)
                begin
                    if ((active == '0) || (block_size_reg == '0))
                    begin
                        eval_status = STAT_STATE;
                    end
                    else
                    begin
                        need_init = 1'b1;
                    end
                end
                else if (!head_valid_reg || (size_reg > block_size_reg))
                begin
                    if (failover_reg)
                    begin
                        eval_fwd = 1'b1;
                    end
                    else
                    begin
                        eval_status = STAT_NOBLOCK;
                    end
                end
                else
                begin
                    need_read = 1'b1;
                end
            end
            ACT_RELEASE:
            begin
                if (!handle_reg)
                begin
                    eval_status = STAT_NULL;
                end
                else if (!pool_ready_reg)
                begin
                    eval_status = STAT_STATE;
                end
                else if ({1'b0, index_reg} >= active)
                begin
                    if (failover_reg)
                    begin
                        eval_fwd = 1'b1;
                    end
                    else
                    begin
                        eval_status = STAT_OWNER;
                    end
                end
                else
                begin
                    release_ok = 1'b1;
                end
            end
            ACT_TEARDOWN:
            begin
                if (!pool_ready_reg)
                begin
                    eval_status = STAT_STATE;
                end
                else if (free_count_reg < active)
                begin
                    eval_status = STAT_INUSE;
                end
                else
                begin
                    eval_fwd    = failover_reg;
                    teardown_ok = 1'b1;
                end
            end
            default:
            begin
                eval_status = STAT_STATE;
            end
        endcase
    end

    assign stat.need_init = need_init;
    assign stat.need_read = need_read;
    assign stat.init_last = init_last;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // Next pool state for setup, pop, push and teardown
    always_comb
    begin
        pool_ready_next = pool_ready_reg;
        free_head_next  = free_head_reg;
        head_valid_next = head_valid_reg;
        free_count_next = free_count_reg;
        if (cmd.init_step && init_last)
        begin
            pool_ready_next = 1'b1;
            free_head_next  = '0;
            head_valid_next = 1'b1;
            free_count_next = active;
        end
        else if (cmd.pop_commit)
        begin
            head_valid_next = (link_rd_reg != '0);
            free_head_next  = (link_rd_reg != '0) ? IDX_W'(link_rd_reg - 11'd1) : '0;
            if (free_count_reg != '0)
            begin
                free_count_next = free_count_reg - 11'd1;
            end
        end
        else if (cmd.eval_commit && release_ok)
        begin
            free_head_next  = index_reg;
            head_valid_next = 1'b1;
            if (free_count_reg != COUNT_MAX)
            begin
                free_count_next = free_count_reg + 11'd1;
            end
        end
        else if (cmd.eval_commit && teardown_ok)
        begin
            pool_ready_next = 1'b0;
        end
    end

    // Select the link memory write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = index_reg;
        mem_wdata = head_valid_reg ? ({1'b0, free_head_reg} + 11'd1) : '0;
        if (cmd.init_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_reg;
            mem_wdata = init_last ? '0 : ({1'b0, init_cnt_reg} + 11'd2);
        end
        else if (cmd.eval_commit && release_ok)
        begin
            mem_we = 1'b1;
        end
    end

    // Write and read the link memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            link_rd_reg <= link_mem[free_head_reg];
        end
    end

    // Hold configuration and pool control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= '0;
            block_size_reg <= '0;
            failover_reg   <= 1'b0;
            pool_ready_reg <= 1'b0;
            free_head_reg  <= '0;
            head_valid_reg <= 1'b0;
            free_count_reg <= '0;
            init_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NUM_BLOCKS: num_blocks_reg <= cfg_data[COUNT_W-1:0];
                    CFG_BLOCK_SIZE: block_size_reg <= cfg_data;
                    CFG_FAILOVER:   failover_reg   <= cfg_data[0];
                    default:        failover_reg   <= failover_reg;
                endcase
            end
            pool_ready_reg <= pool_ready_next;
            free_head_reg  <= free_head_next;
            head_valid_reg <= head_valid_next;
            free_count_reg <= free_count_next;
            if (cmd.init_start)
            begin
                init_cnt_reg <= '0;
            end
            else if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + 10'd1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item, latch the result, drive the output beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= in_action;
            size_reg   <= in_request_size;
            handle_reg <= in_handle_present;
            index_reg  <= in_block_index;
        end
        if (cmd.eval_commit)
        begin
            res_status_reg  <= eval_status;
            res_granted_reg <= '0;
            res_fwd_reg     <= eval_fwd;
        end
        else if (cmd.pop_commit)
        begin
            res_status_reg  <= STAT_OK;
            res_granted_reg <= free_head_reg;
            res_fwd_reg     <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_fwd_reg     <= res_fwd_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_granted_index = out_granted_reg;
    assign out_forwarded     = out_fwd_reg;

endmodule
